/* design/tcce_pkg.sv */
`timescale 1ns / 1ps
package tcce_pkg;

   // fixed field widths
   localparam int CHAR_W      = 8;
   localparam int COLUMNS_W   = 8;
   localparam int ROWS_W      = 7;
   localparam int COLOR_W     = 24;
   localparam int PIXEL_X_W   = 10;
   localparam int PIXEL_Y_W   = 9;
   localparam int CSR_INDEX_W = 3;
   localparam int RSP_DATA_W  = 80;
   localparam int RSP_PAD_W   = RSP_DATA_W - (PIXEL_X_W + PIXEL_Y_W + CHAR_W + 2 * COLOR_W);

   // glyph cell size as a shift
   localparam int GLYPH_SHIFT = 3;

   // character codes
   localparam logic [CHAR_W-1:0] CH_BS        = 8'd8;
   localparam logic [CHAR_W-1:0] CH_LF        = 8'd10;
   localparam logic [CHAR_W-1:0] CH_FF        = 8'd12;
   localparam logic [CHAR_W-1:0] CH_CR        = 8'd13;
   localparam logic [CHAR_W-1:0] GLYPH_SPACE  = 8'd32;
   localparam logic [CHAR_W-1:0] GLYPH_CURSOR = 8'd95;
   localparam logic [CHAR_W-1:0] GLYPH_NONE   = 8'd0;

   // prompt length and position counter
   localparam int PROMPT_LEN = 5;
   localparam logic [2:0] PROMPT_LAST = 3'd4;
   localparam logic [1:0] SUB_SPACE   = 2'd0;
   localparam logic [1:0] SUB_GLYPH   = 2'd1;
   localparam logic [1:0] SUB_CURSOR  = 2'd2;

   // input kinds and output commands
   localparam logic ACT_CHAR  = 1'b0;
   localparam logic ACT_BLINK = 1'b1;
   localparam logic CMD_DRAW  = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_COLUMNS = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROWS    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PROMPT  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FG      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BG      = 3'd4;

   typedef struct packed {
      logic [COLUMNS_W-1:0] columns;
      logic [ROWS_W-1:0]    rows;
      logic                 prompt_mode;
      logic [COLOR_W-1:0]   fg_color;
      logic [COLOR_W-1:0]   bg_color;
   } csr_type;

   localparam csr_type CSR_RESET = '{
      columns:     8'd80,
      rows:        7'd25,
      prompt_mode: 1'b0,
      fg_color:    24'hFF0000,
      bg_color:    24'h000000
   };

   // steps of one item
   typedef enum logic [2:0] {
      ST_ERASE,
      ST_HEAD_CLEAR,
      ST_GLYPH,
      ST_PROMPT,
      ST_FINISH
   } step_type;

   // prompt text "|#|> "
   function automatic logic [CHAR_W-1:0] prompt_glyph(input logic [2:0] idx);
      logic [CHAR_W-1:0] g;
      case (idx)
         3'd0:    g = 8'd124;
         3'd1:    g = 8'd35;
         3'd2:    g = 8'd124;
         3'd3:    g = 8'd62;
         default: g = 8'd32;
      endcase
      return g;
   endfunction

endpackage

/* design/text_console_cursor_engine_core.sv */
`timescale 1ns / 1ps
// channel  dir  handshake               payload
// req      in   req_tvalid/req_tready   tdata: char_code; tuser: action
// rsp      out  rsp_tvalid/rsp_tready   tdata: pixel_x..draw_bg; tuser: command; tlast: last
// csr      in   csr_valid/csr_ready     csr_index, csr_data
//
// one result word leaves per cycle, unless rsp stalls, through a single output register;
// an item emits one result word per step: blink 1, plain char 3 or 4, backspace 2 or 3,
// new line or form feed 2 to 3, and up to 18 with the prompt printed.
// the next item is taken in the cycle its predecessor emits its last word.
// reset (synchronous) homes the cursor, clears blink and loads register defaults.
// a stalled rsp side holds the output register and pauses the step sequencer.
module text_console_cursor_engine_core #(
   parameter int MAX_COLS = 128,
   parameter int MAX_ROWS = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [tcce_pkg::CHAR_W-1:0]          req_tdata,   // char_code
   input  logic                                 req_tuser,   // action
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // pixel_x, pixel_y, glyph, draw_fg, draw_bg, zero pad
   output logic [tcce_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                 rsp_tuser,   // command
   output logic                                 rsp_tlast,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [tcce_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [tcce_pkg::COLOR_W-1:0]         csr_data
);
   import tcce_pkg::*;

   localparam int COL_W  = $clog2(MAX_COLS + 1);
   localparam int ROW_W  = $clog2(MAX_ROWS + 1);
   localparam int PX_W   = COL_W + GLYPH_SHIFT;
   localparam int PY_W   = ROW_W + GLYPH_SHIFT;
   localparam int CCMP_W = COLUMNS_W + 2;
   localparam int RCMP_W = ROWS_W + 2;

   csr_type csr;

   // configuration registers
   assign csr_ready = 1'b1;

   tcce_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .regs     (csr)
   );

   // clamped screen size
   logic [CCMP_W-1:0] cols_x;
   logic [RCMP_W-1:0] rows_x;
   logic [COL_W-1:0]  eff_cols;
   logic [ROW_W-1:0]  eff_rows;

   always_comb begin
      cols_x = CCMP_W'(csr.columns);
      rows_x = RCMP_W'(csr.rows);
      if (cols_x < CCMP_W'(8)) begin
         eff_cols = COL_W'(8);
      end else if (cols_x > CCMP_W'(MAX_COLS)) begin
         eff_cols = COL_W'(MAX_COLS);
      end else begin
         eff_cols = COL_W'(cols_x);
      end
      if (rows_x < RCMP_W'(1)) begin
         eff_rows = ROW_W'(1);
      end else if (rows_x > RCMP_W'(MAX_ROWS)) begin
         eff_rows = ROW_W'(MAX_ROWS);
      end else begin
         eff_rows = ROW_W'(rows_x);
      end
   end

   // item and cursor state
   logic              item_valid_ff, item_valid_in;
   logic              act_ff, act_in;
   logic [CHAR_W-1:0] char_ff, char_in;
   step_type          step_ff, step_in;
   logic [2:0]        pidx_ff, pidx_in;
   logic [1:0]        psub_ff, psub_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic              blink_ff, blink_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_cmd_ff, rsp_cmd_in;
   logic [PIXEL_X_W-1:0] rsp_px_ff, rsp_px_in;
   logic [PIXEL_Y_W-1:0] rsp_py_ff, rsp_py_in;
   logic [CHAR_W-1:0]  rsp_glyph_ff, rsp_glyph_in;
   logic [COLOR_W-1:0] rsp_fg_ff, rsp_fg_in;
   logic [COLOR_W-1:0] rsp_bg_ff, rsp_bg_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               out_free;
   logic               fire;
   logic               accept;
   logic               em_cmd;
   logic [COL_W-1:0]   em_col;
   logic [ROW_W-1:0]   em_row;
   logic [CHAR_W-1:0]  em_glyph;
   logic [COLOR_W-1:0] em_fg;
   logic               em_last;
   logic [COL_W-1:0]   col_inc;
   logic [ROW_W-1:0]   row_inc;
   logic               wrap;
   logic [COL_W-1:0]   fin_col;
   logic [ROW_W-1:0]   fin_row;
   logic [PX_W-1:0]    px_wide;
   logic [PY_W-1:0]    py_wide;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign fire       = item_valid_ff && out_free;
   assign req_tready = !item_valid_ff || (fire && em_last);
   assign accept     = req_tvalid && req_tready;

   assign col_inc = col_ff + COL_W'(1);
   assign row_inc = row_ff + ROW_W'(1);
   assign wrap    = col_ff >= eff_cols;
   assign fin_col = wrap ? '0 : col_ff;
   assign fin_row = wrap ? row_inc : row_ff;

   // step sequencer: one result word per step
   always_comb begin
      item_valid_in = item_valid_ff;
      act_in        = act_ff;
      char_in       = char_ff;
      step_in       = step_ff;
      pidx_in       = pidx_ff;
      psub_in       = psub_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      blink_in      = blink_ff;
      em_cmd        = CMD_DRAW;
      em_col        = col_ff;
      em_row        = row_ff;
      em_glyph      = GLYPH_SPACE;
      em_fg         = csr.fg_color;
      em_last       = 1'b0;

      unique case (step_ff)
         ST_ERASE: begin
            pidx_in = '0;
            psub_in = SUB_SPACE;
            if (act_ff == ACT_BLINK) begin
               em_glyph = GLYPH_CURSOR;
               em_fg    = blink_ff ? csr.fg_color : csr.bg_color;
               em_last  = 1'b1;
               blink_in = ~blink_ff;
            end else begin
               case (char_ff) inside
                  CH_CR, CH_LF: begin
                     col_in = '0;
                     if (row_inc >= eff_rows) begin
                        step_in = ST_HEAD_CLEAR;
                     end else begin
                        row_in  = row_inc;
                        step_in = csr.prompt_mode ? ST_PROMPT : ST_FINISH;
                     end
                  end
                  CH_FF: begin
                     step_in = ST_HEAD_CLEAR;
                  end
                  CH_BS: begin
                     if (!csr.prompt_mode || col_ff > COL_W'(PROMPT_LEN)) begin
                        if (col_ff != '0) begin
                           col_in = col_ff - COL_W'(1);
                        end else if (row_ff != '0) begin
                           col_in = eff_cols - COL_W'(1);
                           row_in = row_ff - ROW_W'(1);
                        end
                     end
                     step_in = ST_FINISH;
                  end
                  default: begin
                     step_in = ST_GLYPH;
                  end
               endcase
            end
         end
         ST_HEAD_CLEAR: begin
            em_cmd   = CMD_CLEAR;
            em_col   = '0;
            em_row   = '0;
            em_glyph = GLYPH_NONE;
            em_fg    = '0;
            col_in   = '0;
            row_in   = '0;
            step_in  = csr.prompt_mode ? ST_PROMPT : ST_FINISH;
         end
         ST_GLYPH: begin
            em_glyph = char_ff;
            col_in   = col_inc;
            step_in  = ST_FINISH;
         end
         ST_PROMPT: begin
            // space, prompt glyph, then cursor one cell right
            em_col = COL_W'(pidx_ff);
            case (psub_ff)
               SUB_SPACE: begin
                  em_glyph = GLYPH_SPACE;
                  psub_in  = SUB_GLYPH;
               end
               SUB_GLYPH: begin
                  em_glyph = prompt_glyph(pidx_ff);
                  psub_in  = SUB_CURSOR;
               end
               default: begin
                  em_col   = COL_W'(pidx_ff) + COL_W'(1);
                  em_glyph = GLYPH_CURSOR;
                  psub_in  = SUB_SPACE;
                  if (pidx_ff == PROMPT_LAST) begin
                     col_in  = COL_W'(PROMPT_LEN);
                     step_in = ST_FINISH;
                  end else begin
                     pidx_in = pidx_ff + 3'd1;
                  end
               end
            endcase
         end
         ST_FINISH: begin
            if (fin_row >= eff_rows) begin
               em_cmd   = CMD_CLEAR;
               em_col   = '0;
               em_row   = '0;
               em_glyph = GLYPH_NONE;
               em_fg    = '0;
               col_in   = '0;
               row_in   = '0;
            end else begin
               em_col   = fin_col;
               em_row   = fin_row;
               em_glyph = GLYPH_CURSOR;
               em_last  = 1'b1;
               col_in   = fin_col;
               row_in   = fin_row;
            end
         end
         default: begin
            step_in = ST_ERASE;
         end
      endcase

      // hold everything while the output register is full
      if (!fire) begin
         step_in  = step_ff;
         pidx_in  = pidx_ff;
         psub_in  = psub_ff;
         col_in   = col_ff;
         row_in   = row_ff;
         blink_in = blink_ff;
      end else if (em_last) begin
         item_valid_in = 1'b0;
         step_in       = ST_ERASE;
      end

      if (accept) begin
         item_valid_in = 1'b1;
         act_in        = req_tuser;
         char_in       = req_tdata;
         step_in       = ST_ERASE;
      end
   end

   // result word
   assign px_wide = PX_W'(em_col) << GLYPH_SHIFT;
   assign py_wide = PY_W'(em_row) << GLYPH_SHIFT;

   always_comb begin
      rsp_valid_in = fire || (rsp_valid_ff && !rsp_tready);
      rsp_cmd_in   = rsp_cmd_ff;
      rsp_px_in    = rsp_px_ff;
      rsp_py_in    = rsp_py_ff;
      rsp_glyph_in = rsp_glyph_ff;
      rsp_fg_in    = rsp_fg_ff;
      rsp_bg_in    = rsp_bg_ff;
      rsp_last_in  = rsp_last_ff;
      if (fire) begin
         rsp_cmd_in   = em_cmd;
         rsp_px_in    = PIXEL_X_W'(px_wide);
         rsp_py_in    = PIXEL_Y_W'(py_wide);
         rsp_glyph_in = em_glyph;
         rsp_fg_in    = em_fg;
         rsp_bg_in    = csr.bg_color;
         rsp_last_in  = em_last;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         step_ff       <= ST_ERASE;
         pidx_ff       <= '0;
         psub_ff       <= SUB_SPACE;
         col_ff        <= '0;
         row_ff        <= '0;
         blink_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         step_ff       <= step_in;
         pidx_ff       <= pidx_in;
         psub_ff       <= psub_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         blink_ff      <= blink_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      act_ff       <= act_in;
      char_ff      <= char_in;
      rsp_cmd_ff   <= rsp_cmd_in;
      rsp_px_ff    <= rsp_px_in;
      rsp_py_ff    <= rsp_py_in;
      rsp_glyph_ff <= rsp_glyph_in;
      rsp_fg_ff    <= rsp_fg_in;
      rsp_bg_ff    <= rsp_bg_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_cmd_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_bg_ff, rsp_fg_ff, rsp_glyph_ff,
                        rsp_py_ff, rsp_px_ff};

`ifndef ASSERT_OFF
   // a clear word carries no position, glyph or foreground
   a_clear_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_cmd_ff == CMD_CLEAR) |->
      (rsp_px_ff == '0 && rsp_py_ff == '0 && rsp_glyph_ff == GLYPH_NONE && rsp_fg_ff == '0))
      else $error("clear word with nonzero draw fields");

   // a taken item always starts with the erase step
   a_accept_start: assert property (@(posedge clock) disable iff (reset)
      accept |=> (item_valid_ff && step_ff == ST_ERASE))
      else $error("accepted item did not start at erase");

   // prompt counter stays inside the five-glyph text
   a_prompt_range: assert property (@(posedge clock) disable iff (reset)
      (step_ff == ST_PROMPT) |-> (pidx_ff <= PROMPT_LAST && psub_ff <= SUB_CURSOR))
      else $error("prompt counter out of range");
`endif

endmodule

/* design/tcce_csr.sv */
`timescale 1ns / 1ps
module tcce_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 wr_en,
   input  logic [tcce_pkg::CSR_INDEX_W-1:0]     wr_index,
   input  logic [tcce_pkg::COLOR_W-1:0]         wr_data,
   output tcce_pkg::csr_type                    regs
);
   import tcce_pkg::*;

   csr_type regs_ff, regs_in;

   // register write decode
   always_comb begin
      regs_in = regs_ff;
      if (wr_en) begin
         unique case (wr_index)
            CSR_COLUMNS: regs_in.columns     = wr_data[COLUMNS_W-1:0];
            CSR_ROWS:    regs_in.rows        = wr_data[ROWS_W-1:0];
            CSR_PROMPT:  regs_in.prompt_mode = wr_data[0];
            CSR_FG:      regs_in.fg_color    = wr_data;
            CSR_BG:      regs_in.bg_color    = wr_data;
            default:     regs_in = regs_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= CSR_RESET;
      end else begin
         regs_ff <= regs_in;
      end
   end

   assign regs = regs_ff;

endmodule
